// ===== hdl/bmtb_pkg.sv =====
// Package for the bitmap text row blitter: action, character and register codes,
// state type and shared status struct. No dependencies.
package bmtb_pkg;

   localparam int GLYPH_ADDR_W = 12;
   localparam int STORE_DEPTH  = 4096;
   localparam int GLYPH_PIXELS = 8;
   localparam int RECIP_STEPS  = 33;

   localparam logic [15:0] SPACE_ADVANCE = 16'd8;
   localparam logic [15:0] TAB_ADVANCE   = 16'd40;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_BEGIN = 2'd1;
   localparam logic [1:0] ACT_CHAR  = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd0;
   localparam logic [2:0] REG_SCREEN_WIDTH = 3'd1;
   localparam logic [2:0] REG_CLIP_LEFT    = 3'd2;
   localparam logic [2:0] REG_CLIP_RIGHT   = 3'd3;
   localparam logic [2:0] REG_CLIP_TOP     = 3'd4;
   localparam logic [2:0] REG_CLIP_BOTTOM  = 3'd5;
   localparam logic [2:0] REG_DEPTH_BUFFER = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DRAW = 3'b100
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } recip_stat_type;

endpackage

// ===== hdl/bmtb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds when read enable is low. No dependencies.
module bmtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/bmtb_recip.sv =====
// Bit-serial restoring divider computing floor(2^32 / divisor), saturated to 32 bits.
// Depends on bmtb_pkg for the step count and status struct.
module bmtb_recip (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              divisor,
   output bmtb_pkg::recip_stat_type stat,
   output logic [31:0]              quotient
);
   import bmtb_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] q_ff, q_in;
   logic [31:0] d_ff, d_in;
   logic [32:0] shifted;
   logic        ge;

   always_comb begin
      shifted = {rem_ff[31:0], cnt_ff == 6'(RECIP_STEPS)};
      ge      = shifted >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      if (start) begin
         d_in   = divisor;
         rem_in = '0;
         q_in   = '0;
         cnt_in = 6'(RECIP_STEPS);
         if (divisor == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? shifted - {1'b0, d_ff} : shifted;
         q_in   = {q_ff[31:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff[32] ? '1 : q_ff[31:0];

endmodule

// ===== hdl/bitmap_text_row_blitter_top.sv =====
// Top level of the bitmap text row blitter: cursor control, glyph store, row emitter.
// Depends on bmtb_pkg, bmtb_ram and bmtb_recip.
//
//   channel | direction | handshake         | word
//   req_    | in        | req_valid/ready   | load, begin or character item
//   rsp_    | out       | rsp_valid/ready   | one clipped glyph row write
//   csr_    | in        | csr_we            | register write, index and data
//
// Load and control characters leave the block in idle; a begin holds req_ready low while the 33-step divider runs.
// A drawn glyph makes one store read per row for h rows, where h is the glyph height.
// Synchronous reset clears cursor, colour, depth; presets registers; glyph store not cleared.
// A stalled rsp_ready holds the row pipeline and the store read data in place.
module bitmap_text_row_blitter_top #(
   parameter int MAX_GLYPH_ROWS = 16,
   parameter int GLYPH_COUNT    = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [11:0]        req_font_address,
   input  logic [7:0]         req_font_byte,
   input  logic signed [15:0] req_origin_x,
   input  logic signed [15:0] req_origin_y,
   input  logic [31:0]        req_depth,
   input  logic [7:0]         req_color,
   input  logic [7:0]         req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [28:0] rsp_row_offset,
   output logic [7:0]         rsp_pixel_mask,
   output logic [7:0]         rsp_pixel_color,
   output logic [31:0]        rsp_inverse_depth,
   output logic               rsp_depth_test,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import bmtb_pkg::*;

   localparam int RW = $clog2(MAX_GLYPH_ROWS + 1);

   // configuration
   logic [4:0]  glyph_height_ff;
   logic [12:0] screen_width_ff;
   logic [15:0] clip_left_ff, clip_right_ff, clip_top_ff, clip_bottom_ff;
   logic        depth_buffer_ff;

   // string state
   state_type   state_ff, state_in;
   logic [15:0] line_start_x_ff, line_start_x_in;
   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] cursor_y_ff, cursor_y_in;
   logic [7:0]  draw_color_ff, draw_color_in;
   logic [31:0] depth_recip_ff, depth_recip_in;

   // glyph in flight
   logic [15:0]             gx_ff, gx_in;
   logic [15:0]             gy_ff, gy_in;
   logic [7:0]              win_ff, win_in;
   logic [GLYPH_ADDR_W-1:0] base_ff, base_in;
   logic [RW-1:0]           h_ff, h_in;
   logic [RW-1:0]           row_ff, row_in;

   // read stage
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_vis_ff, s1_vis_in;
   logic               s1_last_ff, s1_last_in;
   logic signed [28:0] s1_prod_ff, s1_prod_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [28:0] rsp_offset_ff;
   logic [7:0]         rsp_mask_ff, rsp_color_ff;
   logic [31:0]        rsp_invd_ff;
   logic               rsp_dt_ff, rsp_last_ff;

   logic                    accept, advance, issue, depth_test;
   logic [RW-1:0]           h_eff;
   logic [7:0]              win;
   logic signed [17:0]      col, yr, yr_next;
   logic signed [13:0]      sw_s;
   logic signed [31:0]      prod;
   logic                    ram_we;
   logic [GLYPH_ADDR_W-1:0] ram_raddr;
   logic [7:0]              ram_rdata;
   logic                    recip_start;
   recip_stat_type          recip_stat;
   logic [31:0]             recip_q;

   bmtb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_font_address),
      .wdata (req_font_byte),
      .re    (issue),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bmtb_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (recip_start),
      .divisor  (req_depth),
      .stat     (recip_stat),
      .quotient (recip_q)
   );

   assign req_ready   = state_ff == ST_IDLE;
   assign accept      = req_valid && req_ready;
   assign ram_we      = accept && req_action == ACT_LOAD;
   assign recip_start = accept && req_action == ACT_BEGIN;
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign issue       = state_ff == ST_DRAW && advance && row_ff < h_ff;
   assign ram_raddr   = base_ff + GLYPH_ADDR_W'(row_ff);
   assign depth_test  = depth_buffer_ff && depth_recip_ff != '0;

   always_comb begin
      if (32'(glyph_height_ff) > MAX_GLYPH_ROWS) begin
         h_eff = RW'(MAX_GLYPH_ROWS);
      end else begin
         h_eff = RW'(glyph_height_ff);
      end
   end

   always_comb begin
      win = '0;
      col = '0;
      for (int i = 0; i < GLYPH_PIXELS; i++) begin
         col = $signed({{2{cursor_x_ff[15]}}, cursor_x_ff}) + 18'(i);
         win[GLYPH_PIXELS-1-i] = col >= $signed({{2{clip_left_ff[15]}}, clip_left_ff}) &&
                                 col <  $signed({{2{clip_right_ff[15]}}, clip_right_ff});
      end
   end

   always_comb begin
      yr      = $signed({{2{gy_ff[15]}}, gy_ff}) + $signed(18'(row_ff));
      yr_next = yr + 18'sd1;
      sw_s    = $signed({1'b0, screen_width_ff});
      prod    = yr * sw_s;
   end

   always_comb begin
      state_in        = state_ff;
      line_start_x_in = line_start_x_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      draw_color_in   = draw_color_ff;
      depth_recip_in  = depth_recip_ff;
      gx_in           = gx_ff;
      gy_in           = gy_ff;
      win_in          = win_ff;
      base_in         = base_ff;
      h_in            = h_ff;
      row_in          = row_ff;
      s1_valid_in     = s1_valid_ff;
      s1_vis_in       = s1_vis_ff;
      s1_last_in      = s1_last_ff;
      s1_prod_in      = s1_prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_BEGIN: begin
                     line_start_x_in = req_origin_x;
                     cursor_x_in     = req_origin_x;
                     cursor_y_in     = req_origin_y;
                     draw_color_in   = req_color;
                     state_in        = ST_DIV;
                  end
                  ACT_CHAR: begin
                     case (req_char_code)
                        CH_NUL, CH_CR: begin
                        end
                        CH_LF: begin
                           cursor_y_in = cursor_y_ff + 16'(h_eff);
                           cursor_x_in = line_start_x_ff;
                        end
                        CH_SPACE: begin
                           cursor_x_in = cursor_x_ff + SPACE_ADVANCE;
                        end
                        CH_TAB: begin
                           cursor_x_in = cursor_x_ff + TAB_ADVANCE;
                        end
                        default: begin
                           cursor_x_in = cursor_x_ff + SPACE_ADVANCE;
                           gx_in       = cursor_x_ff;
                           gy_in       = cursor_y_ff;
                           win_in      = win;
                           base_in     = GLYPH_ADDR_W'(req_char_code * h_eff);
                           h_in        = h_eff;
                           row_in      = '0;
                           s1_valid_in = 1'b0;
                           if (32'(req_char_code) < GLYPH_COUNT && win != '0 &&
                               h_eff != '0) begin
                              state_in = ST_DRAW;
                           end
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (recip_stat.done) begin
               depth_recip_in = recip_q;
               state_in       = ST_IDLE;
            end
         end
         ST_DRAW: begin
            if (advance) begin
               s1_valid_in = issue;
               if (issue) begin
                  s1_vis_in  = yr >= $signed({{2{clip_top_ff[15]}}, clip_top_ff}) &&
                               yr <  $signed({{2{clip_bottom_ff[15]}}, clip_bottom_ff});
                  s1_last_in = row_ff == h_ff - RW'(1) ||
                               yr_next >= $signed({{2{clip_bottom_ff[15]}}, clip_bottom_ff});
                  s1_prod_in = prod[28:0];
                  row_in     = row_ff + RW'(1);
               end
            end
            if (row_ff == h_ff && !s1_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = advance ? (s1_valid_ff && s1_vis_ff) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_height_ff <= 5'd16;
         screen_width_ff <= 13'd320;
         clip_left_ff    <= 16'd0;
         clip_right_ff   <= 16'd320;
         clip_top_ff     <= 16'd0;
         clip_bottom_ff  <= 16'd200;
         depth_buffer_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_GLYPH_HEIGHT: glyph_height_ff <= csr_wdata[4:0];
            REG_SCREEN_WIDTH: screen_width_ff <= csr_wdata[12:0];
            REG_CLIP_LEFT:    clip_left_ff    <= csr_wdata;
            REG_CLIP_RIGHT:   clip_right_ff   <= csr_wdata;
            REG_CLIP_TOP:     clip_top_ff     <= csr_wdata;
            REG_CLIP_BOTTOM:  clip_bottom_ff  <= csr_wdata;
            REG_DEPTH_BUFFER: depth_buffer_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         line_start_x_ff <= '0;
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         draw_color_ff   <= '0;
         depth_recip_ff  <= '0;
         row_ff          <= '0;
         h_ff            <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         line_start_x_ff <= line_start_x_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         draw_color_ff   <= draw_color_in;
         depth_recip_ff  <= depth_recip_in;
         row_ff          <= row_in;
         h_ff            <= h_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      win_ff     <= win_in;
      base_ff    <= base_in;
      s1_vis_ff  <= s1_vis_in;
      s1_last_ff <= s1_last_in;
      s1_prod_ff <= s1_prod_in;
      if (advance && s1_valid_ff) begin
         rsp_offset_ff <= $signed({{13{gx_ff[15]}}, gx_ff}) + s1_prod_ff;
         rsp_mask_ff   <= ram_rdata & win_ff;
         rsp_color_ff  <= draw_color_ff;
         rsp_invd_ff   <= depth_test ? depth_recip_ff : '0;
         rsp_dt_ff     <= depth_test;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_row_offset    = rsp_offset_ff;
   assign rsp_pixel_mask    = rsp_mask_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_inverse_depth = rsp_invd_ff;
   assign rsp_depth_test    = rsp_dt_ff;
   assign rsp_last          = rsp_last_ff;

   a_stage_in_draw: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> state_ff == ST_DRAW)
      else $error("read stage busy outside draw");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAW |-> row_ff <= h_ff)
      else $error("row counter past glyph height");

   a_recip_done_in_div: assert property (@(posedge clock) disable iff (reset)
      recip_stat.done |-> state_ff == ST_DIV)
      else $error("divider finished outside begin");

   a_busy_after_begin: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_BEGIN && req_depth != '0) |=> recip_stat.busy)
      else $error("divider did not start");

endmodule
